FILE: hdl/ddo_pkg.sv
`default_nettype none
package ddo_pkg;

  localparam logic [31:0] TICK_LENGTH_RESET    = 32'd366334;
  localparam logic [31:0] INV_WHEEL_BASE_RESET = 32'd72944320;
  localparam logic [15:0] MOTION_THRESH_RESET  = 16'd7;

  // 2^32 / (2 pi), rounded
  localparam logic [31:0] INV_TWO_PI_BAM = 32'd683565276;
  // cordic start vector, q4.30
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam int unsigned DIV_STEPS = 42;
  localparam int unsigned CNT_W = 6;

  localparam logic [1:0] CFG_TICK_LENGTH    = 2'd0;
  localparam logic [1:0] CFG_INV_WHEEL_BASE = 2'd1;
  localparam logic [1:0] CFG_MOTION_THRESH  = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MUL_L, ST_MUL_R, ST_SUM, ST_DIV_LOAD, ST_DIV, ST_CHECK,
    ST_MUL_D0, ST_MUL_D1, ST_RAD, ST_MUL_K0, ST_MUL_K1, ST_ANGLE,
    ST_ROT_LOAD, ST_ROT, ST_MUL_X, ST_MUL_Y, ST_POS_Y, ST_OUT
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_TAKE, OP_MUL_L, OP_MUL_R, OP_SUM, OP_DIV_LOAD, OP_DIV,
    OP_MUL_D0, OP_MUL_D1, OP_RAD, OP_MUL_K0, OP_MUL_K1, OP_ANGLE,
    OP_ROT_LOAD, OP_ROT, OP_MUL_X, OP_MUL_Y, OP_POS_Y, OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [4:0] iter;
  } dp_cmd_t;

  typedef struct packed {
    logic action;
    logic primed;
    logic dt_ok;
    logic moving;
    logic out_free;
  } dp_status_t;

  function automatic logic [31:0] atan_bam(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/ddo_ctrl.sv
`default_nettype none
module ddo_ctrl
  import ddo_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  dp_status_t      status,
  output dp_cmd_t         cmd
);

  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);
  localparam logic [CNT_W-1:0] ROT_LAST = CNT_W'(CORDIC_STEPS - 1);

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      ST_IDLE: begin
        if (in_valid && !status.action && status.primed && status.dt_ok) begin
          state_next = ST_MUL_L;
        end
      end
      ST_MUL_L:    state_next = ST_MUL_R;
      ST_MUL_R:    state_next = ST_SUM;
      ST_SUM:      state_next = ST_DIV_LOAD;
      ST_DIV_LOAD: begin
        state_next = ST_DIV;
        cnt_next   = '0;
      end
      ST_DIV: begin
        cnt_next = cnt + 1'b1;
        if (cnt == DIV_LAST) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK:    state_next = status.moving ? ST_MUL_D0 : ST_OUT;
      ST_MUL_D0:   state_next = ST_MUL_D1;
      ST_MUL_D1:   state_next = ST_RAD;
      ST_RAD:      state_next = ST_MUL_K0;
      ST_MUL_K0:   state_next = ST_MUL_K1;
      ST_MUL_K1:   state_next = ST_ANGLE;
      ST_ANGLE:    state_next = ST_ROT_LOAD;
      ST_ROT_LOAD: begin
        state_next = ST_ROT;
        cnt_next   = '0;
      end
      ST_ROT: begin
        cnt_next = cnt + 1'b1;
        if (cnt == ROT_LAST) begin
          state_next = ST_MUL_X;
        end
      end
      ST_MUL_X:    state_next = ST_MUL_Y;
      ST_MUL_Y:    state_next = ST_POS_Y;
      ST_POS_Y:    state_next = ST_OUT;
      ST_OUT: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op   = OP_NONE;
    cmd.iter = cnt[4:0];
    in_stall = (state != ST_IDLE);
    case (state)
      ST_IDLE:     cmd.op = in_valid ? OP_TAKE : OP_NONE;
      ST_MUL_L:    cmd.op = OP_MUL_L;
      ST_MUL_R:    cmd.op = OP_MUL_R;
      ST_SUM:      cmd.op = OP_SUM;
      ST_DIV_LOAD: cmd.op = OP_DIV_LOAD;
      ST_DIV:      cmd.op = OP_DIV;
      ST_CHECK:    cmd.op = OP_NONE;
      ST_MUL_D0:   cmd.op = OP_MUL_D0;
      ST_MUL_D1:   cmd.op = OP_MUL_D1;
      ST_RAD:      cmd.op = OP_RAD;
      ST_MUL_K0:   cmd.op = OP_MUL_K0;
      ST_MUL_K1:   cmd.op = OP_MUL_K1;
      ST_ANGLE:    cmd.op = OP_ANGLE;
      ST_ROT_LOAD: cmd.op = OP_ROT_LOAD;
      ST_ROT:      cmd.op = OP_ROT;
      ST_MUL_X:    cmd.op = OP_MUL_X;
      ST_MUL_Y:    cmd.op = OP_MUL_Y;
      ST_POS_Y:    cmd.op = OP_POS_Y;
      ST_OUT:      cmd.op = status.out_free ? OP_OUT : OP_NONE;
      default:     cmd.op = OP_NONE;
    endcase
  end

endmodule
`default_nettype wire

FILE: hdl/ddo_datapath.sv
`default_nettype none
module ddo_datapath
  import ddo_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  dp_cmd_t                 cmd,
  output dp_status_t              status,
  input  wire logic               cfg_write,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               action,
  input  wire logic [15:0]        sample_time,
  input  wire logic [15:0]        left_count,
  input  wire logic [15:0]        right_count,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      left_speed,
  output logic signed [31:0]      right_speed,
  output logic signed [31:0]      pose_x,
  output logic signed [31:0]      pose_y,
  output logic [31:0]             heading
);

  // configuration
  logic [31:0] tick_length, inverse_wheel_base;
  logic [15:0] motion_threshold;

  // stored sample and pose
  logic [15:0] last_time, last_left, last_right;
  logic        primed;
  logic [31:0] pos_x, pos_y, angle;

  // per-request work registers
  logic [14:0] dt;
  logic [15:0] dl_mag, dr_mag;
  logic        dl_neg, dr_neg;
  logic [63:0] prod;
  logic [47:0] magl, magr, dmag;
  logic        dneg;
  logic [31:0] mean_mag;
  logic        mean_neg;
  logic [41:0] numl, numr;
  logic [14:0] reml, remr;
  logic [31:0] acc;
  logic [48:0] rad;
  logic        flip;
  logic signed [33:0] cx, cy, cz;

  logic [31:0] ma, mb;
  logic [15:0] dt_raw, dl_raw, dr_raw;
  logic signed [48:0] travl, travr;
  logic signed [49:0] tsum, tdiff;
  logic signed [32:0] mean;
  logic [32:0] mean_neg33;
  logic [49:0] dabs;
  logic [31:0] step;
  logic [31:0] rot_sum, rot_u;
  logic signed [33:0] xs, ys, atan_ext, x_abs, y_abs;
  logic [63:0] pos_delta;
  logic        pneg;
  logic        move_l, move_r;

  function automatic logic [41:0] scale_speed(input logic [47:0] m);
    logic [57:0] w;
    // times 1000, then drop 16 fraction bits
    w = {m, 10'b0} - {6'b0, m, 4'b0} - {7'b0, m, 3'b0};
    return w[57:16];
  endfunction

  function automatic logic [31:0] sat_speed(input logic [41:0] q, input logic neg);
    logic [31:0] r;
    if (q[41:31] != '0) begin
      r = neg ? 32'h80000000 : 32'h7fffffff;
    end else begin
      r = neg ? (32'd0 - q[31:0]) : q[31:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] pos_step(input logic [63:0] p, input logic neg);
    logic [63:0] s;
    s = neg ? (64'd0 - p) : p;
    return s[61:30];
  endfunction

  assign dt_raw = sample_time - last_time;
  assign dl_raw = left_count - last_left;
  assign dr_raw = right_count - last_right;

  assign travl = dl_neg ? -$signed({1'b0, magl}) : $signed({1'b0, magl});
  assign travr = dr_neg ? -$signed({1'b0, magr}) : $signed({1'b0, magr});
  assign tsum  = 50'(travl) + 50'(travr);
  assign tdiff = 50'(travr) - 50'(travl);
  assign mean  = tsum[49:17];
  assign mean_neg33 = 33'd0 - 33'(mean);
  assign dabs  = tdiff[49] ? (50'd0 - 50'(tdiff)) : 50'(tdiff);

  assign step     = acc + {prod[23:0], 8'b0};
  assign rot_sum  = angle + 32'h40000000;
  assign rot_u    = angle ^ {rot_sum[31], 31'b0};
  assign xs       = cx >>> cmd.iter;
  assign ys       = cy >>> cmd.iter;
  assign atan_ext = $signed({2'b0, atan_bam(cmd.iter)});
  assign x_abs    = cx[33] ? -cx : cx;
  assign y_abs    = cy[33] ? -cy : cy;

  assign move_l = numl > {26'b0, motion_threshold};
  assign move_r = numr > {26'b0, motion_threshold};

  always_comb begin
    status.action   = action;
    status.primed   = primed;
    status.dt_ok    = !dt_raw[15] && (dt_raw != '0);
    status.moving   = move_l || move_r;
    status.out_free = !out_valid || !out_stall;
  end

  // operand select for the shared multiplier
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      OP_MUL_L: begin
        ma = {16'b0, dl_mag};
        mb = tick_length;
      end
      OP_MUL_R: begin
        ma = {16'b0, dr_mag};
        mb = tick_length;
      end
      OP_MUL_D0: begin
        ma = dmag[31:0];
        mb = inverse_wheel_base;
      end
      OP_MUL_D1: begin
        ma = {16'b0, dmag[47:32]};
        mb = inverse_wheel_base;
      end
      OP_MUL_K0: begin
        ma = rad[31:0];
        mb = INV_TWO_PI_BAM;
      end
      OP_MUL_K1: begin
        ma = {15'b0, rad[48:32]};
        mb = INV_TWO_PI_BAM;
      end
      OP_MUL_X: begin
        ma = mean_mag;
        mb = x_abs[31:0];
      end
      OP_MUL_Y: begin
        ma = mean_mag;
        mb = y_abs[31:0];
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign pneg      = mean_neg ^ flip ^ (cmd.op == OP_MUL_Y ? cx[33] : cy[33]);
  assign pos_delta = prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_length        <= TICK_LENGTH_RESET;
      inverse_wheel_base <= INV_WHEEL_BASE_RESET;
      motion_threshold   <= MOTION_THRESH_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_TICK_LENGTH:    tick_length        <= cfg_data;
        CFG_INV_WHEEL_BASE: inverse_wheel_base <= cfg_data;
        CFG_MOTION_THRESH:  motion_threshold   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_time  <= '0;
      last_left  <= '0;
      last_right <= '0;
      primed     <= 1'b0;
      pos_x      <= '0;
      pos_y      <= '0;
      angle      <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.op == OP_OUT) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        OP_TAKE: begin
          if (action) begin
            pos_x <= '0;
            pos_y <= '0;
            angle <= '0;
          end else if (!primed || status.dt_ok) begin
            last_time  <= sample_time;
            last_left  <= left_count;
            last_right <= right_count;
            primed     <= 1'b1;
          end
        end
        OP_ANGLE: angle <= dneg ? (angle - step) : (angle + step);
        OP_MUL_Y: pos_x <= pos_x + pos_step(pos_delta, pneg);
        OP_POS_Y: pos_y <= pos_y + pos_step(pos_delta, pneg);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= 64'(ma) * 64'(mb);
    case (cmd.op)
      OP_TAKE: begin
        dt     <= dt_raw[14:0];
        dl_neg <= dl_raw[15];
        dr_neg <= dr_raw[15];
        dl_mag <= dl_raw[15] ? (16'd0 - dl_raw) : dl_raw;
        dr_mag <= dr_raw[15] ? (16'd0 - dr_raw) : dr_raw;
      end
      OP_MUL_R: magl <= prod[47:0];
      OP_SUM:   magr <= prod[47:0];
      OP_DIV_LOAD: begin
        numl     <= scale_speed(magl);
        numr     <= scale_speed(magr);
        reml     <= '0;
        remr     <= '0;
        mean_neg <= mean[32];
        mean_mag <= mean[32] ? mean_neg33[31:0] : mean[31:0];
        dneg     <= tdiff[49];
        dmag     <= dabs[47:0];
      end
      OP_DIV: begin
        // one restoring step per lane
        if ({reml, numl[41]} >= {1'b0, dt}) begin
          reml <= 15'({reml, numl[41]} - {1'b0, dt});
          numl <= {numl[40:0], 1'b1};
        end else begin
          reml <= {reml[13:0], numl[41]};
          numl <= {numl[40:0], 1'b0};
        end
        if ({remr, numr[41]} >= {1'b0, dt}) begin
          remr <= 15'({remr, numr[41]} - {1'b0, dt});
          numr <= {numr[40:0], 1'b1};
        end else begin
          remr <= {remr[13:0], numr[41]};
          numr <= {numr[40:0], 1'b0};
        end
      end
      OP_MUL_D1: acc <= prod[63:32];
      OP_RAD:    rad <= {1'b0, prod[47:0]} + {17'b0, acc};
      OP_MUL_K1: acc <= prod[55:24];
      OP_ROT_LOAD: begin
        // headings in the left half plane are turned by pi first
        flip <= rot_sum[31];
        cx   <= CORDIC_GAIN;
        cy   <= '0;
        cz   <= {{2{rot_u[31]}}, rot_u};
      end
      OP_ROT: begin
        if (!cz[33]) begin
          cx <= cx - ys;
          cy <= cy + xs;
          cz <= cz - atan_ext;
        end else begin
          cx <= cx + ys;
          cy <= cy - xs;
          cz <= cz + atan_ext;
        end
      end
      OP_OUT: begin
        left_speed  <= sat_speed(numl, dl_neg);
        right_speed <= sat_speed(numr, dr_neg);
        pose_x      <= pos_x;
        pose_y      <= pos_y;
        heading     <= angle;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

FILE: hdl/differential_drive_odometry_top.sv
// sequence: an accepted request runs ST_MUL_L, ST_MUL_R, ST_SUM, the 42-step bit-serial
// speed divider and ST_CHECK; with motion it then runs the heading steps, the cordic
// rotation of CORDIC_STEPS steps and the position updates; all end in ST_OUT. Pose reset,
// first and dropped samples are taken in ST_IDLE and give no output. in_stall holds off
// new requests until the result leaves ST_OUT, so a stalled output holds the block too
// reset: synchronous, clears pose, stored sample and control; config takes its defaults
`default_nettype none
module differential_drive_odometry_top
  import ddo_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               action,
  input  wire logic [15:0]        sample_time,
  input  wire logic [15:0]        left_count,
  input  wire logic [15:0]        right_count,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      left_speed,
  output logic signed [31:0]      right_speed,
  output logic signed [31:0]      pose_x,
  output logic signed [31:0]      pose_y,
  output logic [31:0]             heading
);

  dp_cmd_t    cmd;
  dp_status_t status;

  ddo_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  ddo_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .action      (action),
    .sample_time (sample_time),
    .left_count  (left_count),
    .right_count (right_count),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .left_speed  (left_speed),
    .right_speed (right_speed),
    .pose_x      (pose_x),
    .pose_y      (pose_y),
    .heading     (heading)
  );

endmodule
`default_nettype wire
